// ===== rtl/scrolled_tile_background_renderer_defines.svh =====
// assertion macros for the tile background renderer
`ifndef SCROLLED_TILE_BACKGROUND_RENDERER_DEFINES_SVH
`define SCROLLED_TILE_BACKGROUND_RENDERER_DEFINES_SVH
`ifndef SYNTHESIS
`define STBR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define STBR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define STBR_ASSERT_IMP(lbl, ante, cons, msg)
`define STBR_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/stbr_pkg.sv =====
// shared types, constants and shade table of the tile background renderer
package stbr_pkg;

  localparam int unsigned VRAM_BYTES = 8192;
  localparam int unsigned ADDR_W     = $clog2(VRAM_BYTES);
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_CONTROL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_Y        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_X        = 2'd2;

  localparam logic [7:0] DISPLAY_CONTROL_RESET = 8'h91;

  localparam int unsigned DISPLAY_ON_BIT  = 7;
  localparam int unsigned BG_ON_BIT       = 0;
  localparam int unsigned MAP_SEL_BIT     = 3;
  localparam int unsigned TILE_UNSIGN_BIT = 4;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  localparam logic [ADDR_W-1:0] SIGNED_TILE_BASE = 13'h0800;
  localparam logic [7:0]        TILE_BIAS        = 8'h80;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LO,
    ST_HI,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic rd_lo;
    logic rd_hi;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic pixel_req;
    logic bg_on;
    logic out_free;
  } status_t;

  function automatic logic [7:0] shade(input logic [1:0] color);
    logic [7:0] g;
    case (color)
      2'd0:    g = 8'd255;
      2'd1:    g = 8'd170;
      2'd2:    g = 8'd85;
      default: g = 8'd0;
    endcase
    return g;
  endfunction

endpackage

// ===== rtl/stbr_ctrl.sv =====
// sequencer for write items and the three video memory reads of a pixel
module stbr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  stbr_pkg::status_t status_i,
  output logic              in_stall_o,
  output stbr_pkg::cmd_t    cmd_o
);
  import stbr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && status_i.pixel_req) begin
          state_d = status_i.bg_on ? ST_LO : ST_DONE;
        end
      end
      ST_LO:   state_d = ST_HI;
      ST_HI:   state_d = ST_DONE;
      ST_DONE: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_LO:   cmd_o.rd_lo = 1'b1;
      ST_HI:   cmd_o.rd_hi = 1'b1;
      ST_DONE: cmd_o.out_load = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ===== rtl/stbr_datapath.sv =====
// registers, video memory, address generation and output register
module stbr_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [stbr_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [stbr_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 kind_i,
  input  logic [stbr_pkg::ADDR_W-1:0]          vram_address_i,
  input  logic [7:0]                           vram_data_i,
  input  logic [7:0]                           line_i,
  input  logic [7:0]                           column_i,
  input  stbr_pkg::cmd_t                       cmd_i,
  output stbr_pkg::status_t                    status_o,
  input  logic                                 out_stall_i,
  output logic                                 out_valid_o,
  output logic [7:0]                           pixel_line_o,
  output logic [7:0]                           pixel_column_o,
  output logic [1:0]                           color_index_o,
  output logic [7:0]                           gray_level_o,
  output logic                                 pixel_shown_o
);
  import stbr_pkg::*;

  logic [7:0] disp_ctrl_q, scroll_y_q, scroll_x_q;

  logic [7:0] mem [VRAM_BYTES];
  logic [7:0] rd_data_q;

  logic [7:0]        line_q, column_q;
  logic [2:0]        fine_y_q, fine_x_q;
  logic              shown_q, tile_unsigned_q;
  logic [ADDR_W-1:0] row_q;
  logic [7:0]        lo_q;

  logic              out_valid_q;
  logic [7:0]        out_line_q, out_column_q, out_gray_q;
  logic [1:0]        out_color_q;
  logic              out_shown_q;

  logic [7:0]        y_sum, x_sum;
  logic              bg_on, pixel_req;
  logic [ADDR_W-1:0] map_addr, signed_row, row_addr, mem_addr;
  logic              mem_we, mem_re;
  logic [2:0]        bit_sel;
  logic [1:0]        color;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disp_ctrl_q <= DISPLAY_CONTROL_RESET;
      scroll_y_q  <= '0;
      scroll_x_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_DISPLAY_CONTROL: disp_ctrl_q <= cfg_data_i;
        REG_SCROLL_Y:        scroll_y_q  <= cfg_data_i;
        REG_SCROLL_X:        scroll_x_q  <= cfg_data_i;
        default:             ;
      endcase
    end
  end

  assign bg_on     = disp_ctrl_q[DISPLAY_ON_BIT] && disp_ctrl_q[BG_ON_BIT];
  assign pixel_req = (kind_i == KIND_PIXEL);
  assign y_sum     = line_i + scroll_y_q;
  assign x_sum     = column_i + scroll_x_q;
  assign map_addr  = {2'b11, disp_ctrl_q[MAP_SEL_BIT], y_sum[7:3], x_sum[7:3]};

  // tile row address from the tile index just read
  assign signed_row = SIGNED_TILE_BASE + {1'b0, rd_data_q ^ TILE_BIAS, 4'b0000};
  assign row_addr   = tile_unsigned_q ? {1'b0, rd_data_q, fine_y_q, 1'b0}
                                      : (signed_row | {9'b0, fine_y_q, 1'b0});

  always_comb begin
    mem_addr = row_addr;
    if (cmd_i.load) begin
      mem_addr = pixel_req ? map_addr : vram_address_i;
    end else if (cmd_i.rd_hi) begin
      mem_addr = {row_q[ADDR_W-1:1], 1'b1};
    end
  end

  assign mem_we = cmd_i.load && (kind_i == KIND_WRITE);
  assign mem_re = (cmd_i.load && pixel_req && bg_on) || cmd_i.rd_lo || cmd_i.rd_hi;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= vram_data_i;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && pixel_req) begin
      line_q          <= line_i;
      column_q        <= column_i;
      fine_y_q        <= y_sum[2:0];
      fine_x_q        <= x_sum[2:0];
      shown_q         <= bg_on;
      tile_unsigned_q <= disp_ctrl_q[TILE_UNSIGN_BIT];
    end
    if (cmd_i.rd_lo) begin
      row_q <= row_addr;
    end
    if (cmd_i.rd_hi) begin
      lo_q <= rd_data_q;
    end
  end

  // leftmost pixel is bit 7
  assign bit_sel = ~fine_x_q;
  assign color   = shown_q ? {rd_data_q[bit_sel], lo_q[bit_sel]} : 2'b00;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_line_q   <= line_q;
      out_column_q <= column_q;
      out_color_q  <= color;
      out_gray_q   <= shown_q ? shade(color) : 8'd0;
      out_shown_q  <= shown_q;
    end
  end

  assign status_o.pixel_req = pixel_req;
  assign status_o.bg_on     = bg_on;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign pixel_line_o   = out_line_q;
  assign pixel_column_o = out_column_q;
  assign color_index_o  = out_color_q;
  assign gray_level_o   = out_gray_q;
  assign pixel_shown_o  = out_shown_q;

endmodule

// ===== rtl/scrolled_tile_background_renderer.sv =====
// tile map background renderer top level
// write item: the block takes the next item on the following cycle
// shown pixel: holds the input through map read, low plane, high plane and output load
// its result is registered at output load; no new item is taken until then
// hidden pixel: no reads, goes straight to output load; a stalled result holds input
// reset idles the sequencer and restores register defaults; video memory is kept
`include "scrolled_tile_background_renderer_defines.svh"

module scrolled_tile_background_renderer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [stbr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [stbr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            kind_i,
  input  logic [stbr_pkg::ADDR_W-1:0]     vram_address_i,
  input  logic [7:0]                      vram_data_i,
  input  logic [7:0]                      line_i,
  input  logic [7:0]                      column_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      pixel_line_o,
  output logic [7:0]                      pixel_column_o,
  output logic [1:0]                      color_index_o,
  output logic [7:0]                      gray_level_o,
  output logic                            pixel_shown_o
);
  import stbr_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    pixel_taken;

  assign pixel_taken = in_valid_i && !in_stall_o && (kind_i == KIND_PIXEL);

  stbr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  stbr_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .kind_i         (kind_i),
    .vram_address_i (vram_address_i),
    .vram_data_i    (vram_data_i),
    .line_i         (line_i),
    .column_i       (column_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .pixel_line_o   (pixel_line_o),
    .pixel_column_o (pixel_column_o),
    .color_index_o  (color_index_o),
    .gray_level_o   (gray_level_o),
    .pixel_shown_o  (pixel_shown_o)
  );

  `STBR_ASSERT_IMP(a_cmd_onehot, 1'b1, $onehot0(cmd), "more than one datapath command")
  `STBR_ASSERT_NXT(a_pixel_blocks, pixel_taken, in_stall_o, "pixel item did not block the input")
  `STBR_ASSERT_NXT(a_out_load, cmd.out_load, out_valid_o, "loaded result not presented")

endmodule

// ===== dv/tb_scrolled_tile_background_renderer.sv =====
// self-checking testbench for the scrolled tile background renderer
module tb_scrolled_tile_background_renderer;
  import stbr_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned IDLE_PERCENT  = 23;
  localparam int unsigned RAND_PHASES   = 8;
  localparam int unsigned PHASE_ITEMS   = 125;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED    = 2'd3;
  localparam logic [ADDR_W-1:0]    MAP_LOW_BASE  = 13'h1800;
  localparam logic [ADDR_W-1:0]    MAP_HIGH_BASE = 13'h1C00;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    logic [7:0]        ln;
    logic [7:0]        col;
  } render_item_t;

  typedef struct packed {
    logic [7:0] pix_line;
    logic [7:0] pix_column;
    logic [1:0] color;
    logic [7:0] gray;
    logic       shown;
  } pixel_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  kind = KIND_WRITE;
  logic [ADDR_W-1:0]     vram_address = '0;
  logic [7:0]            vram_data = '0;
  logic [7:0]            line = '0;
  logic [7:0]            column = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            pixel_line;
  logic [7:0]            pixel_column;
  logic [1:0]            color_index;
  logic [7:0]            gray_level;
  logic                  pixel_shown;

  scrolled_tile_background_renderer i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .kind_i         (kind),
    .vram_address_i (vram_address),
    .vram_data_i    (vram_data),
    .line_i         (line),
    .column_i       (column),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .pixel_line_o   (pixel_line),
    .pixel_column_o (pixel_column),
    .color_index_o  (color_index),
    .gray_level_o   (gray_level),
    .pixel_shown_o  (pixel_shown)
  );

  // pending stimulus and its generation-time view of video memory
  render_item_t pending_items[$];
  render_item_t next_item;
  logic [7:0]   gen_mem [VRAM_BYTES];
  bit           gen_known [VRAM_BYTES];
  logic [7:0]   gen_ctrl = DISPLAY_CONTROL_RESET;
  logic [7:0]   gen_scroll_y = '0;
  logic [7:0]   gen_scroll_x = '0;
  int unsigned  n_queued = 0;
  bit           quiet = 1'b0;

  // predictor state, updated as items and register writes land
  logic [7:0]   pred_vram [VRAM_BYTES];
  logic [7:0]   shadow_ctrl;
  logic [7:0]   shadow_scroll_y;
  logic [7:0]   shadow_scroll_x;
  pixel_t       expected_pixels[$];
  pixel_t       exp_pix;
  logic         in_taken;

  int unsigned  n_writes = 0;
  int unsigned  n_pixels = 0;
  int unsigned  n_shown = 0;
  int unsigned  n_errors = 0;
  int unsigned  clk_ticks = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [ADDR_W-1:0] map_entry_addr(input logic [7:0] ctrl,
      input logic [7:0] sy, input logic [7:0] sx, input logic [7:0] ln,
      input logic [7:0] col);
    logic [7:0] y;
    logic [7:0] x;
    y = ln + sy;
    x = col + sx;
    return (ctrl[MAP_SEL_BIT] ? MAP_HIGH_BASE : MAP_LOW_BASE) + ADDR_W'({y[7:3], x[7:3]});
  endfunction

  function automatic logic [ADDR_W-1:0] plane_addr(input logic [7:0] ctrl,
      input logic [7:0] sy, input logic [7:0] ln, input logic [7:0] tile);
    logic [7:0]        y;
    logic [7:0]        biased;
    logic [ADDR_W-1:0] base;
    y = ln + sy;
    biased = tile + TILE_BIAS;
    if (ctrl[TILE_UNSIGN_BIT]) begin
      base = ADDR_W'({tile, 4'b0000});
    end else begin
      base = SIGNED_TILE_BASE + ADDR_W'({biased, 4'b0000});
    end
    return base + ADDR_W'({y[2:0], 1'b0});
  endfunction

  function automatic logic [7:0] gray_of(input logic [1:0] color);
    case (color)
      2'd0:    return 8'd255;
      2'd1:    return 8'd170;
      2'd2:    return 8'd85;
      default: return 8'd0;
    endcase
  endfunction

  function automatic pixel_t render_pixel(input logic [7:0] ln, input logic [7:0] col);
    pixel_t            p;
    logic [ADDR_W-1:0] ra;
    logic [7:0]        tile;
    logic [7:0]        lo;
    logic [7:0]        hi;
    logic [7:0]        x;
    logic [2:0]        b;
    p.pix_line = ln;
    p.pix_column = col;
    p.color = 2'd0;
    p.gray = 8'd0;
    p.shown = 1'b0;
    if (shadow_ctrl[DISPLAY_ON_BIT] && shadow_ctrl[BG_ON_BIT]) begin
      tile = pred_vram[map_entry_addr(shadow_ctrl, shadow_scroll_y, shadow_scroll_x, ln, col)];
      ra = plane_addr(shadow_ctrl, shadow_scroll_y, ln, tile);
      lo = pred_vram[ra];
      hi = pred_vram[ra + 13'd1];
      x = col + shadow_scroll_x;
      b = 3'd7 - x[2:0];
      p.color = {hi[b], lo[b]};
      p.gray = gray_of(p.color);
      p.shown = 1'b1;
    end
    return p;
  endfunction

  task automatic push_write(input logic [ADDR_W-1:0] addr, input logic [7:0] data,
      input logic [7:0] ln, input logic [7:0] col);
    gen_mem[addr] = data;
    gen_known[addr] = 1'b1;
    pending_items.push_back('{KIND_WRITE, addr, data, ln, col});
    n_queued++;
  endtask

  task automatic push_random_write(input logic [ADDR_W-1:0] addr);
    push_write(addr, 8'($urandom_range(255)), 8'($urandom_range(255)),
               8'($urandom_range(255)));
  endtask

  // loads any video memory the pixel would read before queueing the request
  task automatic push_pixel(input logic [7:0] ln, input logic [7:0] col,
      input logic [ADDR_W-1:0] addr, input logic [7:0] data);
    logic [ADDR_W-1:0] ma;
    logic [ADDR_W-1:0] ra;
    if (gen_ctrl[DISPLAY_ON_BIT] && gen_ctrl[BG_ON_BIT]) begin
      ma = map_entry_addr(gen_ctrl, gen_scroll_y, gen_scroll_x, ln, col);
      if (!gen_known[ma]) push_random_write(ma);
      ra = plane_addr(gen_ctrl, gen_scroll_y, ln, gen_mem[ma]);
      if (!gen_known[ra]) push_random_write(ra);
      if (!gen_known[ra + 13'd1]) push_random_write(ra + 13'd1);
    end
    pending_items.push_back('{KIND_PIXEL, addr, data, ln, col});
    n_queued++;
  endtask

  task automatic push_pixel_on_tile(input logic [7:0] ln, input logic [7:0] col,
      input logic [7:0] tile);
    push_write(map_entry_addr(gen_ctrl, gen_scroll_y, gen_scroll_x, ln, col), tile, ln, col);
    push_pixel(ln, col, 13'($urandom_range(8191)), 8'($urandom_range(255)));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      REG_DISPLAY_CONTROL: gen_ctrl = data;
      REG_SCROLL_Y:        gen_scroll_y = data;
      REG_SCROLL_X:        gen_scroll_x = data;
      default: ;
    endcase
  endtask

  task automatic begin_phase(input logic [7:0] ctrl, input logic [7:0] sy,
      input logic [7:0] sx);
    write_reg(REG_DISPLAY_CONTROL, ctrl);
    write_reg(REG_SCROLL_Y, sy);
    write_reg(REG_SCROLL_X, sx);
    @(posedge clk_i);
  endtask

  task automatic drain();
    do begin
      @(posedge clk_i);
    end while (pending_items.size() != 0 || in_valid || expected_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // input driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_items.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PERCENT)) begin
        next_item = pending_items.pop_front();
        kind <= next_item.kind;
        vram_address <= next_item.addr;
        vram_data <= next_item.data;
        line <= next_item.ln;
        column <= next_item.col;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk_i) begin
    out_stall <= !quiet && ($urandom_range(99) < IDLE_PERCENT);
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_ctrl <= DISPLAY_CONTROL_RESET;
      shadow_scroll_y <= '0;
      shadow_scroll_x <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DISPLAY_CONTROL: shadow_ctrl <= cfg_data;
        REG_SCROLL_Y:        shadow_scroll_y <= cfg_data;
        REG_SCROLL_X:        shadow_scroll_x <= cfg_data;
        default: ;
      endcase
    end
  end

  // monitor: predicts on accepted items, checks accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        if (kind == KIND_WRITE) begin
          pred_vram[vram_address] = vram_data;
          n_writes++;
        end else begin
          expected_pixels.push_back(render_pixel(line, column));
          n_pixels++;
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected pixel result at line %0d column %0d", pixel_line, pixel_column);
          n_errors++;
        end else begin
          exp_pix = expected_pixels.pop_front();
          if (pixel_shown) n_shown++;
          if (pixel_line !== exp_pix.pix_line) begin
            $error("pixel_line: expected %0d, got %0d", exp_pix.pix_line, pixel_line);
            n_errors++;
          end
          if (pixel_column !== exp_pix.pix_column) begin
            $error("pixel_column: expected %0d, got %0d", exp_pix.pix_column, pixel_column);
            n_errors++;
          end
          if (color_index !== exp_pix.color) begin
            $error("color_index: expected %0d, got %0d", exp_pix.color, color_index);
            n_errors++;
          end
          if (gray_level !== exp_pix.gray) begin
            $error("gray_level: expected %0d, got %0d", exp_pix.gray, gray_level);
            n_errors++;
          end
          if (pixel_shown !== exp_pix.shown) begin
            $error("pixel_shown: expected %0d, got %0d", exp_pix.shown, pixel_shown);
            n_errors++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    clk_ticks <= clk_ticks + 1;
    if (clk_ticks == CYCLE_LIMIT) begin
      $display("timeout with %0d items pending, %0d results outstanding",
               pending_items.size(), expected_pixels.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [7:0]  ctrl;
    int unsigned target;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings, field extremes, off-screen coordinates
    push_write(13'd8191, 8'd255, 8'd255, 8'd255);
    push_write(13'd0, 8'd0, 8'd0, 8'd0);
    push_pixel(8'd0, 8'd0, 13'd8191, 8'd255);
    push_pixel(8'd143, 8'd159, 13'd0, 8'd0);
    push_pixel(8'd255, 8'd255, 13'd4096, 8'd170);
    push_pixel(8'd144, 8'd160, 13'd1, 8'd85);
    drain();

    // everything disabled, maximum scroll, write to an unused register index
    write_reg(REG_UNUSED, 8'hFF);
    begin_phase(8'h00, 8'd255, 8'd255);
    push_pixel(8'd0, 8'd0, 13'd0, 8'd0);
    push_pixel(8'd255, 8'd255, 13'd8191, 8'd255);
    drain();

    // display on with background off, then background on with display off
    begin_phase(8'h80, 8'd3, 8'd5);
    push_pixel(8'd20, 8'd30, 13'd0, 8'd0);
    drain();
    begin_phase(8'h01, 8'd0, 8'd0);
    push_pixel(8'd20, 8'd30, 13'd0, 8'd0);
    drain();

    // all control bits set: high map, unsigned tiles
    begin_phase(8'hFF, 8'd255, 8'd255);
    push_pixel(8'd0, 8'd0, 13'd0, 8'd0);
    push_pixel(8'd255, 8'd255, 13'd8191, 8'd255);
    push_pixel(8'd143, 8'd159, 13'd0, 8'd0);
    drain();

    // signed tile data around the bias boundary
    begin_phase(8'h81, 8'd128, 8'd7);
    push_pixel_on_tile(8'd0, 8'd0, 8'h00);
    push_pixel_on_tile(8'd255, 8'd255, 8'h7F);
    push_pixel_on_tile(8'd77, 8'd200, 8'h80);
    push_pixel_on_tile(8'd9, 8'd17, 8'hFF);
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      ctrl = 8'($urandom_range(255));
      if ($urandom_range(99) < 80) begin
        ctrl[DISPLAY_ON_BIT] = 1'b1;
        ctrl[BG_ON_BIT] = 1'b1;
      end
      quiet = (ph == 3);
      begin_phase(ctrl, 8'($urandom_range(255)), 8'($urandom_range(255)));
      target = n_queued + PHASE_ITEMS;
      while (n_queued < target) begin
        if ($urandom_range(99) < 60) begin
          if ($urandom_range(99) < 75) begin
            push_pixel(8'($urandom_range(143)), 8'($urandom_range(159)),
                       13'($urandom_range(8191)), 8'($urandom_range(255)));
          end else begin
            push_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                       13'($urandom_range(8191)), 8'($urandom_range(255)));
          end
        end else begin
          push_random_write(13'($urandom_range(8191)));
        end
      end
      drain();
      quiet = 1'b0;
    end

    $display("covered %0d video memory writes and %0d pixel requests (%0d shown)",
             n_writes, n_pixels, n_shown);
    $display("over %0d register settings, in %0d cycles", 6 + RAND_PHASES, clk_ticks);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/stbr_pkg.sv
rtl/stbr_ctrl.sv
rtl/stbr_datapath.sv
rtl/scrolled_tile_background_renderer.sv
dv/tb_scrolled_tile_background_renderer.sv
